[hw/rtl/rotation_matrix_to_euler_macros.svh]
// assertion macros for the rotation matrix to euler checker
`ifndef ROTATION_MATRIX_TO_EULER_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_MACROS_SVH

// property sampled at clk and ignored while reset is low
`define RME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[hw/rtl/rme_pkg.sv]
// shared constants, types and the arctangent table of the euler angle pipeline
package rme_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 23;
  localparam int OPW          = 25;
  localparam int CW           = 34;
  localparam int ZW           = 33;

  localparam logic signed [15:0] PI_Q13      = 16'sd25736;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [ZW-1:0] HALF_PI_Q29 = 33'sd843314857;
  localparam logic [14:0] THR_RESET = 15'd16351;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_t;

  typedef struct packed {
    pole_t              pole;
    logic               sat_p;
    logic               sat_n;
    logic signed [15:0] s;
    logic signed [16:0] hy;
    logic signed [16:0] hx;
    logic signed [16:0] by;
    logic signed [16:0] bx;
  } side_t;

  typedef struct packed {
    pole_t pole;
    logic  sat_p;
    logic  sat_n;
  } tail_t;

  // atan(2^-i) in Q.29, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q29(input int i);
    case (i)
      0:  return 33'sd421657428;
      1:  return 33'sd248918915;
      2:  return 33'sd131521918;
      3:  return 33'sd66762580;
      4:  return 33'sd33510843;
      5:  return 33'sd16771758;
      6:  return 33'sd8387925;
      7:  return 33'sd4194219;
      8:  return 33'sd2097141;
      9:  return 33'sd1048575;
      10: return 33'sd524288;
      11: return 33'sd262144;
      12: return 33'sd131072;
      13: return 33'sd65536;
      14: return 33'sd32768;
      15: return 33'sd16384;
      16: return 33'sd8192;
      17: return 33'sd4096;
      18: return 33'sd2048;
      19: return 33'sd1024;
      20: return 33'sd512;
      21: return 33'sd256;
      22: return 33'sd128;
      23: return 33'sd64;
      default: return '0;
    endcase
  endfunction

endpackage

[hw/rtl/rotation_matrix_to_euler.sv]
// pipeline: 44 register stages
// throughput: one matrix per cycle; every stage advances whenever the output
//   register is empty or its result is taken
// stages: input, pole test and square, 23 square root steps, three parallel
//   cordic units of 18 stages, output select
// reset: rst_n synchronous low clears the valid bits and loads threshold 16351
module rotation_matrix_to_euler import rme_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_tvalid,
  output logic         cfg_tready,
  input  logic [15:0]  cfg_tdata,   // pole_threshold[14:0], zero
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,    // m00, m02, m10, m11, m12, m20, m22
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,   // heading[15:0], attitude[14:0], bank[15:0], zero
  output logic [1:0]   out_tuser    // pole_case
);

  localparam int ATAN_LAT = CORDIC_STEPS + 2;
  localparam int NSTG     = 2 + SQRT_STEPS + ATAN_LAT + 1;

  logic [14:0] thr_r;
  logic [NSTG-1:0] vld_r;
  logic en;

  assign en         = !vld_r[NSTG-1] || out_tready;
  assign in_tready  = en;
  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_tvalid) begin
      thr_r <= cfg_tdata[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  // input stage
  logic signed [15:0] m00_r, m02_r, m10_r, m11_r, m12_r, m20_r, m22_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m00_r <= in_tdata[15:0];
      m02_r <= in_tdata[31:16];
      m10_r <= in_tdata[47:32];
      m11_r <= in_tdata[63:48];
      m12_r <= in_tdata[79:64];
      m20_r <= in_tdata[95:80];
      m22_r <= in_tdata[111:96];
    end
  end

  // pole test, operand select and square
  logic signed [16:0] thr_s, m10_x;
  side_t side_nxt, side1_r;
  logic [31:0] sq_r;

  assign thr_s = {2'b00, thr_r};
  assign m10_x = {m10_r[15], m10_r};

  always_comb begin
    side_nxt.s     = m10_r;
    side_nxt.sat_p = m10_r >= ONE_Q14;
    side_nxt.sat_n = m10_r <= -ONE_Q14;
    side_nxt.by    = -{m12_r[15], m12_r};
    side_nxt.bx    = {m11_r[15], m11_r};
    if (m10_x > thr_s || m10_x < -thr_s) begin
      side_nxt.pole = (m10_x > thr_s) ? POLE_NORTH : POLE_SOUTH;
      side_nxt.hy   = {m02_r[15], m02_r};
      side_nxt.hx   = {m22_r[15], m22_r};
    end else begin
      side_nxt.pole = POLE_NONE;
      side_nxt.hy   = -{m20_r[15], m20_r};
      side_nxt.hx   = {m00_r[15], m00_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side_nxt;
      sq_r    <= 32'(m10_r * m10_r);
    end
  end

  // square root of (1 - s^2) in q.22, one result bit per stage
  logic [44:0] sqv_r   [0:SQRT_STEPS-1];
  logic [44:0] sqres_r [0:SQRT_STEPS-1];
  side_t       sside_r [0:SQRT_STEPS-1];
  logic [28:0] rad;
  logic [44:0] v_first;

  assign rad     = 29'(30'd268435456 - 30'(sq_r));
  assign v_first = (side1_r.sat_p || side1_r.sat_n) ? '0 : {rad, 16'b0};

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [44:0] BIT = 45'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [44:0] v_in, res_in, t;
    if (k == 0) begin : g_first
      assign v_in   = v_first;
      assign res_in = '0;
    end else begin : g_rest
      assign v_in   = sqv_r[k-1];
      assign res_in = sqres_r[k-1];
    end
    assign t = res_in + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        sside_r[k] <= (k == 0) ? side1_r : sside_r[(k == 0) ? 0 : k-1];
        if (v_in >= t) begin
          sqv_r[k]   <= v_in - t;
          sqres_r[k] <= (res_in >> 1) + BIT;
        end else begin
          sqv_r[k]   <= v_in;
          sqres_r[k] <= res_in >> 1;
        end
      end
    end
  end

  // three cordic units run side by side
  side_t sd;
  logic signed [OPW-1:0] hx_w, hy_w, bx_w, by_w, ax_w, ay_w;
  logic signed [15:0] ang_h, ang_b, ang_a;

  assign sd   = sside_r[SQRT_STEPS-1];
  assign hx_w = OPW'(sd.hx);
  assign hy_w = OPW'(sd.hy);
  assign bx_w = OPW'(sd.bx);
  assign by_w = OPW'(sd.by);
  assign ax_w = {2'b00, sqres_r[SQRT_STEPS-1][22:0]};
  assign ay_w = {sd.s[15], sd.s, 8'b0};

  rme_atan2 u_head (.clk(clk), .en(en), .x_i(hx_w), .y_i(hy_w), .ang_o(ang_h));
  rme_atan2 u_bank (.clk(clk), .en(en), .x_i(bx_w), .y_i(by_w), .ang_o(ang_b));
  rme_atan2 u_asin (.clk(clk), .en(en), .x_i(ax_w), .y_i(ay_w), .ang_o(ang_a));

  tail_t tail_r [0:ATAN_LAT-1];

  for (genvar j = 0; j < ATAN_LAT; j++) begin : g_tail
    always_ff @(posedge clk) begin
      if (en) begin
        if (j == 0) begin
          tail_r[j] <= '{pole: sd.pole, sat_p: sd.sat_p, sat_n: sd.sat_n};
        end else begin
          tail_r[j] <= tail_r[(j == 0) ? 0 : j-1];
        end
      end
    end
  end

  // output select
  tail_t tl;
  logic signed [15:0] head_nxt, bank_nxt, att_nxt;
  logic signed [15:0] head_r, bank_r;
  logic signed [14:0] att_r;
  pole_t pole_r;

  assign tl = tail_r[ATAN_LAT-1];

  always_comb begin
    head_nxt = ang_h;
    bank_nxt = ang_b;
    if (ang_a > HALF_PI_Q13) begin
      att_nxt = HALF_PI_Q13;
    end else if (ang_a < -HALF_PI_Q13) begin
      att_nxt = -HALF_PI_Q13;
    end else begin
      att_nxt = ang_a;
    end
    if (tl.pole == POLE_NORTH) begin
      att_nxt  = HALF_PI_Q13;
      bank_nxt = '0;
    end else if (tl.pole == POLE_SOUTH) begin
      att_nxt  = -HALF_PI_Q13;
      bank_nxt = '0;
    end else if (tl.sat_p) begin
      att_nxt = HALF_PI_Q13;
    end else if (tl.sat_n) begin
      att_nxt = -HALF_PI_Q13;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      head_r <= head_nxt;
      bank_r <= bank_nxt;
      att_r  <= att_nxt[14:0];
      pole_r <= tl.pole;
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {1'b0, bank_r, att_r, head_r};
  assign out_tuser  = pole_r;

endmodule

[hw/rtl/rme_atan2.sv]
// pipelined vectoring cordic: atan2(y, x) rounded to q3.13 radians
module rme_atan2 import rme_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [OPW-1:0] x_i,
  input  logic signed [OPW-1:0] y_i,
  output logic signed [15:0]    ang_o
);

  logic signed [CW-1:0] x_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] y_r [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z_r [0:CORDIC_STEPS];
  logic                 zero_r [0:CORDIC_STEPS];

  logic signed [CW-1:0] xs, ys, x0_nxt, y0_nxt;
  logic signed [ZW-1:0] z0_nxt;
  logic signed [ZW-1:0] zrnd;
  logic signed [ZW-17:0] rnd;
  logic signed [15:0]   ang_nxt, ang_r;

  assign xs = {{(CW-OPW){x_i[OPW-1]}}, x_i} <<< 8;
  assign ys = {{(CW-OPW){y_i[OPW-1]}}, y_i} <<< 8;

  // move a left half plane vector into the right half plane
  always_comb begin
    x0_nxt = xs;
    y0_nxt = ys;
    z0_nxt = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        x0_nxt = ys;
        y0_nxt = -xs;
        z0_nxt = HALF_PI_Q29;
      end else begin
        x0_nxt = -ys;
        y0_nxt = xs;
        z0_nxt = -HALF_PI_Q29;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0_nxt;
      y_r[0]    <= y0_nxt;
      z_r[0]    <= z0_nxt;
      zero_r[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_q29(i);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_q29(i);
        end
      end
    end
  end

  assign zrnd = z_r[CORDIC_STEPS] + 33'sd32768;
  assign rnd  = zrnd[ZW-1:16];

  always_comb begin
    if (zero_r[CORDIC_STEPS]) begin
      ang_nxt = '0;
    end else if (rnd > 17'(PI_Q13)) begin
      ang_nxt = PI_Q13;
    end else if (rnd < -17'(PI_Q13)) begin
      ang_nxt = -PI_Q13;
    end else begin
      ang_nxt = rnd[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= ang_nxt;
    end
  end

  assign ang_o = ang_r;

endmodule

[hw/rtl/rme_checker.sv]
// port level checks of the euler angle block, bound to its top level
`include "rotation_matrix_to_euler_macros.svh"

module rme_checker import rme_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [47:0]  out_tdata,
  input logic [1:0]   out_tuser
);

  logic [14:0] att;
  logic [15:0] bank;

  assign att  = out_tdata[30:16];
  assign bank = out_tdata[46:31];

  `RME_ASSERT(a_pole_code, out_tvalid |-> (out_tuser == POLE_NONE || out_tuser == POLE_NORTH || out_tuser == POLE_SOUTH), "pole code out of range")
  `RME_ASSERT(a_north, (out_tvalid && out_tuser == POLE_NORTH) |-> (att == HALF_PI_Q13[14:0] && bank == '0), "north pole angles wrong")
  `RME_ASSERT(a_south, (out_tvalid && out_tuser == POLE_SOUTH) |-> (att == 15'(-HALF_PI_Q13) && bank == '0), "south pole angles wrong")
  `RME_ASSERT(a_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "stalled result changed")

endmodule

bind rotation_matrix_to_euler rme_checker u_rme_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

[test/tb_top.sv]
// testbench for the rotation matrix to euler angle pipeline
`timescale 1ns / 1ps

module tb_top;
  import rme_pkg::*;

  typedef struct {
    logic signed [15:0] heading;
    logic signed [14:0] attitude;
    logic signed [15:0] bank;
    pole_t              pole;
  } angles_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_tvalid;
  logic         cfg_tready;
  logic [15:0]  cfg_tdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic [1:0]   out_tuser;

  angles_t expected_angles[$];
  logic [14:0] threshold;
  int  n_errors;
  int  cycle_count;
  bit  idle_enable;

  rotation_matrix_to_euler u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial clk = 1'b0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // arithmetic shift with floor
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint cordic_angle(longint y, longint x);
    longint z, t, dx, dy, r;
    longint tab[24];
    tab = '{421657428, 248918915, 131521918, 66762580, 33510843, 16771758,
            8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
            32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64};
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 843314857;
      end else begin
        x = -y; y = t; z = -843314857;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += tab[i];
      end else begin
        x -= dx; y += dy; z -= tab[i];
      end
    end
    r = shr_floor(z + 32768, 16);
    if (r > 25736) r = 25736;
    if (r < -25736) r = -25736;
    return r;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 46;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint arcsine(longint s);
    longint c, a;
    if (s >= 16384) return 12868;
    if (s <= -16384) return -12868;
    c = int_sqrt(longint'((64'sd1 <<< 28) - s * s) * 65536);
    a = cordic_angle(s * 256, c);
    if (a > 12868) a = 12868;
    if (a < -12868) a = -12868;
    return a;
  endfunction

  function automatic angles_t predict_angles(logic [111:0] d);
    angles_t e;
    longint m00, m02, m10, m11, m12, m20, m22, thr;
    m00 = longint'($signed(d[15:0]));
    m02 = longint'($signed(d[31:16]));
    m10 = longint'($signed(d[47:32]));
    m11 = longint'($signed(d[63:48]));
    m12 = longint'($signed(d[79:64]));
    m20 = longint'($signed(d[95:80]));
    m22 = longint'($signed(d[111:96]));
    thr = longint'(threshold);
    if (m10 > thr || m10 < -thr) begin
      e.heading = 16'(cordic_angle(m02, m22));
      e.attitude = (m10 > thr) ? 15'sd12868 : -15'sd12868;
      e.bank = '0;
      e.pole = (m10 > thr) ? POLE_NORTH : POLE_SOUTH;
    end else begin
      e.heading = 16'(cordic_angle(-m20, m00));
      e.bank = 16'(cordic_angle(-m12, m11));
      e.attitude = 15'(arcsine(m10));
      e.pole = POLE_NONE;
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d",
             what, got, want, cycle_count);
    n_errors++;
  endtask

  // result checker and receiver stalls
  int stall_left;
  always @(posedge clk) begin
    angles_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, 0);
        end else begin
          e = expected_angles.pop_front();
          if ($signed(out_tdata[15:0]) != e.heading)
            report_mismatch("heading", $signed(out_tdata[15:0]), e.heading);
          if ($signed(out_tdata[30:16]) != e.attitude)
            report_mismatch("attitude", $signed(out_tdata[30:16]), e.attitude);
          if ($signed(out_tdata[46:31]) != e.bank)
            report_mismatch("bank", $signed(out_tdata[46:31]), e.bank);
          if (out_tdata[47] !== 1'b0)
            report_mismatch("pad bit", out_tdata[47], 0);
          if (out_tuser != e.pole)
            report_mismatch("pole_case", out_tuser, e.pole);
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_matrix(logic [111:0] d);
    int gap;
    if (idle_enable && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 11);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_angles.push_back(predict_angles(d));
  endtask

  function automatic logic [111:0] pack_matrix(logic [15:0] m00, m02, m10, m11,
                                               m12, m20, m22);
    return {m22, m20, m12, m11, m10, m02, m00};
  endfunction

  task automatic drain_pipeline();
    int limit;
    in_tvalid <= 1'b0;
    limit = 0;
    while (expected_angles.size() != 0 && limit < 100000) begin
      @(posedge clk);
      limit++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic write_threshold(logic [14:0] v);
    cfg_tdata <= {1'b0, v};
    cfg_tvalid <= 1'b1;
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    cfg_tvalid <= 1'b0;
    threshold = v;
  endtask

  task automatic test_directed();
    logic [15:0] edge_vals[6];
    edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'hc000, 16'h4000, 16'hffff};
    send_matrix(pack_matrix(16'h4000, 0, 0, 16'h4000, 0, 0, 16'h4000));
    send_matrix(pack_matrix(0, 0, 0, 0, 0, 0, 0));   // both operands zero
    send_matrix(pack_matrix(16'hc000, 16'h1000, 16'd16351, 16'hc000, 16'h1000,
                            16'h1000, 16'hc000));
    send_matrix(pack_matrix(0, 16'h2000, 16'd16352, 0, 0, 0, 16'hc000)); // north
    send_matrix(pack_matrix(0, 16'he000, -16'sd16352, 0, 0, 0, 16'h2000)); // south
    send_matrix(pack_matrix(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                            16'h7fff, 16'h8000));
    send_matrix(pack_matrix(16'hc000, 0, 16'h8000, 16'hc000, 16'hffff,
                            16'h0001, 0)); // south pole
    foreach (edge_vals[i])
      send_matrix(pack_matrix(edge_vals[i], edge_vals[5 - i], edge_vals[i],
                              edge_vals[(i + 2) % 6], edge_vals[(i + 3) % 6],
                              edge_vals[(i + 4) % 6], edge_vals[(i + 1) % 6]));
    drain_pipeline();
    // threshold extremes: full scale lets asin saturate, zero makes almost all poles
    write_threshold(15'd16384);
    send_matrix(pack_matrix(16'h4000, 0, 16'h4000, 16'h4000, 0, 0, 16'h4000));
    send_matrix(pack_matrix(16'h4000, 0, 16'hc000, 16'h4000, 0, 0, 16'h4000));
    send_matrix(pack_matrix(16'h4000, 0, 16'h6000, 16'h4000, 0, 0, 16'h4000));
    send_matrix(pack_matrix(16'h4000, 0, 16'h8000, 16'h4000, 0, 0, 16'h4000));
    drain_pipeline();
    write_threshold(15'd0);
    send_matrix(pack_matrix(16'h4000, 16'h1000, 0, 16'h4000, 0, 0, 16'h4000));
    send_matrix(pack_matrix(16'h4000, 16'h1000, 1, 16'h4000, 0, 0, 16'h4000));
    send_matrix(pack_matrix(16'h4000, 16'h1000, 16'hffff, 16'h4000, 0, 0, 16'h4000));
    drain_pipeline();
    write_threshold(15'h7fff);
    send_matrix(pack_matrix(16'h1234, 16'h5678, 16'h7fff, 16'h9abc, 16'hdef0,
                            16'h0fed, 16'hcba9));
    drain_pipeline();
  endtask

  // mostly plausible rotations near unit scale, some raw noise
  function automatic logic [15:0] rand_entry(int mode);
    if (mode == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic test_random(int count, logic [14:0] thr);
    int mode;
    logic [15:0] m10;
    write_threshold(thr);
    for (int i = 0; i < count; i++) begin
      mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
      m10 = rand_entry(mode);
      if ($urandom_range(0, 7) == 0)
        m10 = ($urandom_range(0, 1) ? 16'(thr) : -16'(thr)) + 16'($signed($urandom_range(0, 4)) - 2);
      send_matrix(pack_matrix(rand_entry(mode), rand_entry(mode), m10,
                              rand_entry(mode), rand_entry(mode), rand_entry(mode),
                              rand_entry(mode)));
    end
    drain_pipeline();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_tvalid = 1'b0;
    cfg_tdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    n_errors = 0;
    cycle_count = 0;
    threshold = THR_RESET;
    idle_enable = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(400, THR_RESET);
    test_random(300, 15'd8000);
    test_random(300, 15'd16384);
    test_random(200, 15'd0);
    test_random(200, 15'd12000);
    idle_enable = 1'b0;
    test_random(200, THR_RESET);
    // results still owed at the end were lost
    if (expected_angles.size() != 0)
      report_mismatch("missing results", 0, expected_angles.size());
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rme_pkg.sv
hw/rtl/rme_atan2.sv
hw/rtl/rotation_matrix_to_euler.sv
hw/rtl/rme_checker.sv
test/tb_top.sv
